>>> design/chacha_pkg.sv
// Package: types, constants and round helpers for the ChaCha stream cipher.
package chacha_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_A         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_B         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_C         = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_D         = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_NONCE_LOW     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_NONCE_HIGH    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_START_COUNTER = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_ROUND_COUNT   = 3'd7;

    localparam logic [5:0] ROUND_COUNT_RESET = 6'd20;

    localparam logic [3:0][31:0] SIGMA = {
        32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
    };

    typedef logic [3:0][31:0] row_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       message_end;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  result_byte;
        logic [31:0] next_counter;
        logic        result_end;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FEED,
        ST_OUT
    } state_t;

    // Half a quarter round on (a, b, c, d); second selects the 8/7 rotations.
    function automatic row_t qr_half(input row_t q, input logic second);
        logic [31:0] a1;
        logic [31:0] dx;
        logic [31:0] d1;
        logic [31:0] c1;
        logic [31:0] bx;
        logic [31:0] b1;
        row_t        r;
        a1 = q[0] + q[1];
        dx = q[3] ^ a1;
        d1 = second ? {dx[23:0], dx[31:24]} : {dx[15:0], dx[31:16]};
        c1 = q[2] + d1;
        bx = q[1] ^ c1;
        b1 = second ? {bx[24:0], bx[31:25]} : {bx[19:0], bx[31:20]};
        r[0] = a1;
        r[1] = b1;
        r[2] = c1;
        r[3] = d1;
        return r;
    endfunction

    // Rotate a row of four words left by amt word positions.
    function automatic row_t rot_row(input row_t row, input logic [1:0] amt);
        row_t r;
        for (int j = 0; j < 4; j++)
        begin
            r[j] = row[2'(j) + amt];
        end
        return r;
    endfunction

endpackage

>>> design/chacha_stream_cipher.sv
// ChaCha20 (IETF layout) byte stream cipher with one shared half-quarter-round unit.
//
// Each accepted word carries one message byte and is answered with one result word:
// the byte XORed with keystream, the block counter the next byte would use, and the
// message end flag. The 4x4 word state sits in rows that rotate past a single
// half-quarter-round unit in column 0, so the round loop runs one half quarter round
// per cycle. The first byte of a message and every 64th byte after it need a new
// keystream block: a load step, floor(round_count/2) double rounds and a feed-forward
// pass of one word per cycle; every byte also passes an accept and an output step.
// The block takes no new byte while a byte is in work; a finished result waits in an
// output register while the next byte is accepted. Configuration writes are taken at
// any time and should be made only between bytes.
module chacha_stream_cipher
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  data_valid,
    output logic                                  data_ready,
    input  chacha_pkg::in_word_t                  data,

    output logic                                  result_valid,
    input  logic                                  result_ready,
    output chacha_pkg::out_word_t                 result,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [chacha_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [chacha_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // configuration
    logic [63:0] key_a_reg, key_b_reg, key_c_reg, key_d_reg, nonce_low_reg;
    logic [31:0] nonce_high_reg, start_counter_reg;
    logic [5:0]  round_count_reg;

    // control
    chacha_pkg::state_t state_reg, state_next;
    logic        half_reg, half_next;
    logic [1:0]  col_reg, col_next;
    logic        diag_reg, diag_next;
    logic [4:0]  dr_reg, dr_next;
    logic [3:0]  k_reg, k_next;
    logic [5:0]  pos_reg, pos_next;
    logic [31:0] counter_reg, counter_next;
    logic        block_ready_reg, block_ready_next;
    logic        at_start_reg, at_start_next;
    logic        out_valid_reg, out_valid_next;

    // payload
    chacha_pkg::row_t      st_reg [4];
    chacha_pkg::row_t      st_next [4];
    logic [31:0]           ks_reg [16];
    chacha_pkg::in_word_t  in_reg;
    chacha_pkg::out_word_t out_reg, out_next;

    logic              accept;
    logic              out_free;
    logic              last_step;
    logic [31:0]       init_w [16];
    chacha_pkg::row_t  col_in;
    chacha_pkg::row_t  col_out;
    logic [31:0]       feed_word;
    logic [31:0]       ks_word;
    logic [7:0]        ks_byte;
    logic [31:0]       counter_after;

    assign cfg_ready    = 1'b1;
    assign data_ready   = (state_reg == chacha_pkg::ST_IDLE);
    assign accept       = data_valid && data_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign out_free     = !out_valid_reg || result_ready;
    assign last_step    = half_reg && (col_reg == 2'd3) && diag_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            init_w[i] = chacha_pkg::SIGMA[i];
        end
        init_w[4]  = key_a_reg[31:0];
        init_w[5]  = key_a_reg[63:32];
        init_w[6]  = key_b_reg[31:0];
        init_w[7]  = key_b_reg[63:32];
        init_w[8]  = key_c_reg[31:0];
        init_w[9]  = key_c_reg[63:32];
        init_w[10] = key_d_reg[31:0];
        init_w[11] = key_d_reg[63:32];
        init_w[12] = counter_reg;
        init_w[13] = nonce_low_reg[31:0];
        init_w[14] = nonce_low_reg[63:32];
        init_w[15] = nonce_high_reg;
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            col_in[i] = st_reg[i][0];
        end
    end

    assign col_out   = chacha_pkg::qr_half(col_in, half_reg);
    assign feed_word = st_reg[k_reg[3:2]][k_reg[1:0]] + init_w[k_reg];
    assign ks_word   = ks_reg[pos_reg[5:2]];
    assign ks_byte   = ks_word[8*pos_reg[1:0] +: 8];
    assign counter_after = (pos_reg == 6'd63) ? counter_reg + 32'd1 : counter_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            chacha_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (at_start_reg || !block_ready_reg) ?
                                 chacha_pkg::ST_LOAD : chacha_pkg::ST_OUT;
                end
            end
            chacha_pkg::ST_LOAD:
            begin
                state_next = (round_count_reg[5:1] == 5'd0) ?
                             chacha_pkg::ST_FEED : chacha_pkg::ST_ROUND;
            end
            chacha_pkg::ST_ROUND:
            begin
                if (last_step && (dr_reg == 5'd1))
                begin
                    state_next = chacha_pkg::ST_FEED;
                end
            end
            chacha_pkg::ST_FEED:
            begin
                if (k_reg == 4'd15)
                begin
                    state_next = chacha_pkg::ST_OUT;
                end
            end
            chacha_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = chacha_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = chacha_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and counters
    always_comb
    begin
        logic [1:0] amt;
        amt              = 2'd0;
        half_next        = half_reg;
        col_next         = col_reg;
        diag_next        = diag_reg;
        dr_next          = dr_reg;
        k_next           = k_reg;
        pos_next         = pos_reg;
        counter_next     = counter_reg;
        block_ready_next = block_ready_reg;
        at_start_next    = at_start_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg && !result_ready;
        for (int i = 0; i < 4; i++)
        begin
            st_next[i] = st_reg[i];
        end

        unique case (state_reg)
            chacha_pkg::ST_IDLE:
            begin
                if (accept && at_start_reg)
                begin
                    counter_next     = start_counter_reg;
                    pos_next         = 6'd0;
                    block_ready_next = 1'b0;
                    at_start_next    = 1'b0;
                end
            end
            chacha_pkg::ST_LOAD:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        st_next[i][j] = init_w[4*i + j];
                    end
                end
                half_next = 1'b0;
                col_next  = 2'd0;
                diag_next = 1'b0;
                dr_next   = round_count_reg[5:1];
                k_next    = 4'd0;
            end
            chacha_pkg::ST_ROUND:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    st_next[i][0] = col_out[i];
                end
                if (half_reg)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        if (col_reg != 2'd3)
                        begin
                            amt = 2'd1;
                        end
                        else if (!diag_reg)
                        begin
                            amt = 2'(i + 1);
                        end
                        else
                        begin
                            amt = 2'(1 - i);
                        end
                        st_next[i] = chacha_pkg::rot_row(st_next[i], amt);
                    end
                    col_next = col_reg + 2'd1;
                    if (col_reg == 2'd3)
                    begin
                        diag_next = !diag_reg;
                        if (diag_reg)
                        begin
                            dr_next = dr_reg - 5'd1;
                        end
                    end
                end
                half_next = !half_reg;
            end
            chacha_pkg::ST_FEED:
            begin
                k_next = k_reg + 4'd1;
                if (k_reg == 4'd15)
                begin
                    block_ready_next = 1'b1;
                end
            end
            chacha_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    out_next.result_byte  = in_reg.data_byte ^ ks_byte;
                    out_next.next_counter = counter_after;
                    out_next.result_end   = in_reg.message_end;
                    out_valid_next        = 1'b1;
                    pos_next              = pos_reg + 6'd1;
                    counter_next          = counter_after;
                    if (pos_reg == 6'd63)
                    begin
                        block_ready_next = 1'b0;
                    end
                    if (in_reg.message_end)
                    begin
                        at_start_next = 1'b1;
                    end
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_a_reg         <= '0;
            key_b_reg         <= '0;
            key_c_reg         <= '0;
            key_d_reg         <= '0;
            nonce_low_reg     <= '0;
            nonce_high_reg    <= '0;
            start_counter_reg <= '0;
            round_count_reg   <= chacha_pkg::ROUND_COUNT_RESET;
            state_reg         <= chacha_pkg::ST_IDLE;
            half_reg          <= 1'b0;
            col_reg           <= '0;
            diag_reg          <= 1'b0;
            dr_reg            <= '0;
            k_reg             <= '0;
            pos_reg           <= '0;
            counter_reg       <= '0;
            block_ready_reg   <= 1'b0;
            at_start_reg      <= 1'b1;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    chacha_pkg::REG_KEY_A:         key_a_reg         <= cfg_data;
                    chacha_pkg::REG_KEY_B:         key_b_reg         <= cfg_data;
                    chacha_pkg::REG_KEY_C:         key_c_reg         <= cfg_data;
                    chacha_pkg::REG_KEY_D:         key_d_reg         <= cfg_data;
                    chacha_pkg::REG_NONCE_LOW:     nonce_low_reg     <= cfg_data;
                    chacha_pkg::REG_NONCE_HIGH:    nonce_high_reg    <= cfg_data[31:0];
                    chacha_pkg::REG_START_COUNTER: start_counter_reg <= cfg_data[31:0];
                    chacha_pkg::REG_ROUND_COUNT:   round_count_reg   <= cfg_data[5:0];
                    default:                       round_count_reg   <= round_count_reg;
                endcase
            end
            state_reg       <= state_next;
            half_reg        <= half_next;
            col_reg         <= col_next;
            diag_reg        <= diag_next;
            dr_reg          <= dr_next;
            k_reg           <= k_next;
            pos_reg         <= pos_next;
            counter_reg     <= counter_next;
            block_ready_reg <= block_ready_next;
            at_start_reg    <= at_start_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= data;
        end
        for (int i = 0; i < 4; i++)
        begin
            st_reg[i] <= st_next[i];
        end
        if (state_reg == chacha_pkg::ST_FEED)
        begin
            ks_reg[k_reg] <= feed_word;
        end
        out_reg <= out_next;
    end

endmodule

>>> sim/chacha_stream_cipher_tb.sv
// Testbench for chacha_stream_cipher: predicted keystream XOR checked word by word.
module chacha_stream_cipher_tb;

    localparam int RANDOM_ITEMS = 1800;
    localparam int QUIET_TAIL   = 250;
    localparam int HOLD_CYCLES  = 300;
    localparam int STUCK_LIMIT  = 5000;

    class cipher_scoreboard;
        logic [63:0] key_q [4];
        logic [63:0] nonce_lo;
        logic [31:0] nonce_hi;
        logic [31:0] ctr_start;
        logic [5:0]  rounds;

        logic [31:0] ks [16];
        logic [31:0] mix [16];
        logic [5:0]  pos;
        logic [31:0] ctr;
        bit          have_block;
        bit          msg_start;

        chacha_pkg::out_word_t expected_q [$];
        int unsigned mismatches;
        int unsigned bytes;
        int unsigned messages;
        int unsigned writes;
        int unsigned wraps;

        function new();
            foreach (key_q[i])
            begin
                key_q[i] = '0;
            end
            nonce_lo   = '0;
            nonce_hi   = '0;
            ctr_start  = '0;
            rounds     = chacha_pkg::ROUND_COUNT_RESET;
            pos        = '0;
            ctr        = '0;
            have_block = 1'b0;
            msg_start  = 1'b1;
            mismatches = 0;
            bytes      = 0;
            messages   = 0;
            writes     = 0;
            wraps      = 0;
        endfunction

        function void write_reg(logic [chacha_pkg::CFG_INDEX_W-1:0] idx,
                                logic [chacha_pkg::CFG_DATA_W-1:0] val);
            writes++;
            case (idx)
                chacha_pkg::REG_KEY_A:         key_q[0] = val;
                chacha_pkg::REG_KEY_B:         key_q[1] = val;
                chacha_pkg::REG_KEY_C:         key_q[2] = val;
                chacha_pkg::REG_KEY_D:         key_q[3] = val;
                chacha_pkg::REG_NONCE_LOW:     nonce_lo = val;
                chacha_pkg::REG_NONCE_HIGH:    nonce_hi = val[31:0];
                chacha_pkg::REG_START_COUNTER: ctr_start = val[31:0];
                chacha_pkg::REG_ROUND_COUNT:   rounds = val[5:0];
                default:                       ;
            endcase
        endfunction

        function logic [31:0] rotl(logic [31:0] v, int s);
            return (v << s) | (v >> (32 - s));
        endfunction

        function void quarter(int a, int b, int c, int d);
            mix[a] = mix[a] + mix[b];
            mix[d] = rotl(mix[d] ^ mix[a], 16);
            mix[c] = mix[c] + mix[d];
            mix[b] = rotl(mix[b] ^ mix[c], 12);
            mix[a] = mix[a] + mix[b];
            mix[d] = rotl(mix[d] ^ mix[a], 8);
            mix[c] = mix[c] + mix[d];
            mix[b] = rotl(mix[b] ^ mix[c], 7);
        endfunction

        function void make_keystream();
            logic [31:0] init_w [16];
            int dr;
            init_w[0]  = 32'h61707865;
            init_w[1]  = 32'h3320646e;
            init_w[2]  = 32'h79622d32;
            init_w[3]  = 32'h6b206574;
            for (int k = 0; k < 4; k++)
            begin
                init_w[4 + 2 * k] = key_q[k][31:0];
                init_w[5 + 2 * k] = key_q[k][63:32];
            end
            init_w[12] = ctr;
            init_w[13] = nonce_lo[31:0];
            init_w[14] = nonce_lo[63:32];
            init_w[15] = nonce_hi;
            mix = init_w;
            for (dr = 0; dr < int'(rounds >> 1); dr++)
            begin
                quarter(0, 4, 8, 12);
                quarter(1, 5, 9, 13);
                quarter(2, 6, 10, 14);
                quarter(3, 7, 11, 15);
                quarter(0, 5, 10, 15);
                quarter(1, 6, 11, 12);
                quarter(2, 7, 8, 13);
                quarter(3, 4, 9, 14);
            end
            for (int k = 0; k < 16; k++)
            begin
                ks[k] = mix[k] + init_w[k];
            end
            have_block = 1'b1;
        endfunction

        function void note_word(chacha_pkg::in_word_t w);
            chacha_pkg::out_word_t e;
            logic [7:0]            ks_byte;
            if (msg_start)
            begin
                ctr        = ctr_start;
                pos        = '0;
                have_block = 1'b0;
                msg_start  = 1'b0;
                messages++;
            end
            if (!have_block)
            begin
                make_keystream();
            end
            ks_byte = ks[pos[5:2]][{pos[1:0], 3'b000} +: 8];
            pos = pos + 6'd1;
            if (pos == '0)
            begin
                if (ctr == '1)
                begin
                    wraps++;
                end
                ctr        = ctr + 32'd1;
                have_block = 1'b0;
            end
            e.result_byte  = w.data_byte ^ ks_byte;
            e.next_counter = ctr;
            e.result_end   = w.message_end;
            if (w.message_end)
            begin
                msg_start = 1'b1;
            end
            expected_q.push_back(e);
            bytes++;
        endfunction

        function void check_word(chacha_pkg::out_word_t got);
            chacha_pkg::out_word_t e;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result word: byte %h counter %h end %b",
                             got.result_byte, got.next_counter, got.result_end);
                end
                return;
            end
            e = expected_q.pop_front();
            if (got.result_byte !== e.result_byte || got.next_counter !== e.next_counter ||
                got.result_end !== e.result_end)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display({"mismatch: byte exp %h got %h, counter exp %h got %h, ",
                              "end exp %b got %b"},
                             e.result_byte, got.result_byte, e.next_counter, got.next_counter,
                             e.result_end, got.result_end);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                data_valid;
    logic                                data_ready;
    chacha_pkg::in_word_t                data;
    logic                                result_valid;
    logic                                result_ready;
    chacha_pkg::out_word_t               result;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [chacha_pkg::CFG_INDEX_W-1:0]  cfg_index;
    logic [chacha_pkg::CFG_DATA_W-1:0]   cfg_data;

    cipher_scoreboard sb;
    int send_odds;
    int recv_odds;
    int hold_left;
    int random_sent;
    int stuck_cycles;

    chacha_stream_cipher dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .data         (data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                sb.check_word(result);
            end
            if (data_valid && data_ready)
            begin
                sb.note_word(data);
            end
            if (cfg_valid && cfg_ready)
            begin
                sb.write_reg(cfg_index, cfg_data);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (data_valid && data_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles + 1 >= STUCK_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", STUCK_LIMIT);
            $display("FAIL chacha_stream_cipher");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left   = 0;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else if (recv_odds != 0 && $urandom_range(1, recv_odds) == 1)
            begin
                stall_left = $urandom_range(0, 2);
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        chacha_pkg::in_word_t w;
        w.data_byte   = b;
        w.message_end = last;
        @(negedge clk);
        if (send_odds != 0 && $urandom_range(1, send_odds) == 1)
        begin
            data_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        data_valid <= 1'b1;
        data       <= w;
        @(posedge clk);
        while (!data_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic finish_batch();
        @(negedge clk);
        data_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [chacha_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [chacha_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] pick64();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'hFFFF_FFFE;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_odds();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 2;
            2:       return 4;
            default: return 8;
        endcase
    endfunction

    // upper bits of narrow registers carry noise to check masking
    task automatic random_settings(input bit all);
        logic [5:0] r;
        case ($urandom_range(0, 9))
            0:       r = 6'd0;
            1:       r = 6'd1;
            2:       r = 6'd63;
            3:       r = 6'd62;
            4:       r = 6'($urandom_range(0, 63));
            5:       r = 6'd8;
            default: r = 6'd20;
        endcase
        if (all || $urandom_range(0, 1) == 1)
        begin
            write_reg(chacha_pkg::REG_KEY_A, pick64());
        end
        if (all || $urandom_range(0, 1) == 1)
        begin
            write_reg(chacha_pkg::REG_KEY_B, pick64());
        end
        if (all || $urandom_range(0, 1) == 1)
        begin
            write_reg(chacha_pkg::REG_KEY_C, pick64());
        end
        if (all || $urandom_range(0, 1) == 1)
        begin
            write_reg(chacha_pkg::REG_KEY_D, pick64());
        end
        if (all || $urandom_range(0, 1) == 1)
        begin
            write_reg(chacha_pkg::REG_NONCE_LOW, pick64());
        end
        if (all || $urandom_range(0, 1) == 1)
        begin
            write_reg(chacha_pkg::REG_NONCE_HIGH, {$urandom, pick32()});
        end
        if (all || $urandom_range(0, 1) == 1)
        begin
            write_reg(chacha_pkg::REG_START_COUNTER, {$urandom, pick32()});
        end
        if (all || $urandom_range(0, 1) == 1)
        begin
            write_reg(chacha_pkg::REG_ROUND_COUNT, {$urandom, 26'($urandom), r});
        end
    endtask

    // messages of random length; the last one may be cut and resumed next phase
    task automatic send_traffic(input int budget);
        int len;
        int k;
        while (budget > 0)
        begin
            case ($urandom_range(0, 9))
                0:       len = 1;
                1:       len = 64;
                2:       len = 65;
                3:       len = 129;
                default: len = $urandom_range(2, 40);
            endcase
            for (k = 0; k < len && budget > 0; k++)
            begin
                send_byte(8'($urandom_range(0, 255)), k == len - 1);
                budget--;
                random_sent++;
            end
        end
        finish_batch();
    endtask

    initial
    begin
        int phase;
        sb           = new();
        rst_n        = 1'b0;
        data_valid   = 1'b0;
        data         = '0;
        cfg_valid    = 1'b0;
        cfg_index    = chacha_pkg::REG_KEY_A;
        cfg_data     = '0;
        send_odds    = 0;
        recv_odds    = 0;
        hold_left    = 0;
        random_sent  = 0;
        stuck_cycles = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: zero key, counter 0, 20 rounds
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        finish_batch();

        write_reg(chacha_pkg::REG_KEY_A, 64'h0706050403020100);
        write_reg(chacha_pkg::REG_KEY_B, 64'h0f0e0d0c0b0a0908);
        write_reg(chacha_pkg::REG_KEY_C, 64'h1716151413121110);
        write_reg(chacha_pkg::REG_KEY_D, 64'h1f1e1d1c1b1a1918);
        write_reg(chacha_pkg::REG_NONCE_LOW, 64'h4a000000_09000000);
        write_reg(chacha_pkg::REG_NONCE_HIGH, 64'hFFFF_FFFF_0000_0000);
        write_reg(chacha_pkg::REG_START_COUNTER, 64'd1);
        write_reg(chacha_pkg::REG_ROUND_COUNT, 64'd20);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h00, 1'b1);
        finish_batch();

        // zero rounds, widest count, odd count
        write_reg(chacha_pkg::REG_ROUND_COUNT, 64'd0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h3C, 1'b1);
        finish_batch();
        write_reg(chacha_pkg::REG_ROUND_COUNT, '1);
        send_byte(8'h81, 1'b1);
        finish_batch();
        write_reg(chacha_pkg::REG_ROUND_COUNT, 64'd7);
        send_byte(8'h18, 1'b1);
        finish_batch();

        write_reg(chacha_pkg::REG_START_COUNTER, '1);
        send_byte(8'h00, 1'b0);
        finish_batch();
        // writes inside a message: current block and counter stay
        write_reg(chacha_pkg::REG_KEY_A, '1);
        write_reg(chacha_pkg::REG_START_COUNTER, 64'd5);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7E, 1'b1);
        finish_batch();
        send_byte(8'h42, 1'b1);
        finish_batch();

        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (random_sent >= RANDOM_ITEMS - QUIET_TAIL)
            begin
                send_odds = 0;
                recv_odds = 0;
            end
            else
            begin
                send_odds = pick_odds();
                recv_odds = pick_odds();
            end
            random_settings(phase == 0);
            if (phase == 1)
            begin
                hold_left = HOLD_CYCLES;
            end
            send_traffic($urandom_range(40, 200));
            phase++;
        end

        repeat (20) @(posedge clk);
        $display("Ran %0d bytes in %0d messages with %0d register writes over %0d phases;",
                 sb.bytes, sb.messages, sb.writes, phase);
        $display("round counts 0, odd and 63, %0d block counter wraps, mismatches: %0d",
                 sb.wraps, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("PASS chacha_stream_cipher");
        end
        else
        begin
            $display("FAIL chacha_stream_cipher");
        end
        $finish;
    end

endmodule

>>> chacha_stream_cipher.f
design/chacha_pkg.sv
design/chacha_stream_cipher.sv
sim/chacha_stream_cipher_tb.sv
